[sv/fstc_pkg.sv]
// ----------------------------------------------------------------------------
// fstc_pkg
// Shared types and constants for the soft-takeover fader CC emitter.
// ----------------------------------------------------------------------------
package fstc_pkg;

  localparam int unsigned Q_ONE      = 16384;
  localparam int unsigned ENTER_THR  = 1638;
  localparam int unsigned CATCH_THR  = 328;
  localparam int unsigned CHANGE_THR = 16;
  localparam int unsigned RANGE_MIN  = 16;
  localparam int unsigned POS_MAX    = 1000;

  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic CFG_PAGE = 1'b0;
  localparam logic CFG_WIDE = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [2:0] column;
    logic [9:0] position;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cc_number;
    logic [6:0] cc_value;
    logic       last;
  } out_item_t;

  // queued command between front and back
  typedef struct packed {
    logic        kind;
    logic [5:0]  idx;
    logic        ok;
    logic [14:0] pos;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MREAD, ST_MDIV, ST_MDONE, ST_TSCAN, ST_TEND
  } state_t;

endpackage

[sv/fstc_front.sv]
// ----------------------------------------------------------------------------
// fstc_front
// Accepts items, maps move positions to Q1.14, queues commands.
// ----------------------------------------------------------------------------
module fstc_front #(
  parameter int NUM_FADERS      = 32,
  parameter int FADERS_PER_PAGE = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  fstc_pkg::in_item_t in_data,
  input  logic [1:0]        page,
  output logic              q_valid,
  input  logic              q_pop,
  output fstc_pkg::cmd_t    q_data
);
  import fstc_pkg::*;

  logic [9:0]  psat;
  logic [23:0] prod;
  logic [48:0] recip;
  logic [14:0] qpos;
  logic [7:0]  idx_full;
  cmd_t        cmd;
  cmd_t        buf_q [2];
  logic [1:0]  count;
  logic        wp, rp;

  // saturate and scale: (p*16384+500)/1000 via reciprocal multiply,
  // exact for every dividend below 2^24
  always_comb begin
    psat = (in_data.position > 10'(POS_MAX)) ? 10'(POS_MAX) : in_data.position;
    prod = {psat, 14'd0} + 24'd500;
    recip = 49'(prod) * 49'd17179870;
    qpos = recip[48:34];
    idx_full = 8'(page) * 8'(FADERS_PER_PAGE) + 8'(in_data.column);
    cmd.kind = in_data.kind;
    cmd.pos  = qpos;
    cmd.idx  = idx_full[5:0];
    cmd.ok   = (32'(in_data.column) < 32'(FADERS_PER_PAGE)) &&
               (32'(idx_full) < 32'(NUM_FADERS));
  end

  assign in_stall = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_data   = buf_q[rp];

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) buf_q[wp] <= cmd;
    if (rst) begin
      count <= 2'd0; wp <= 1'b0; rp <= 1'b0;
    end else begin
      if (in_valid && !in_stall) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      count <= count + 2'(in_valid && !in_stall) - 2'(q_pop);
    end
  end
endmodule

[sv/fstc_back.sv]
// ----------------------------------------------------------------------------
// fstc_back
// Executes moves (pickup, iterative divide) and scans ticks into CC messages.
// ----------------------------------------------------------------------------
module fstc_back #(
  parameter int NUM_FADERS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wide,
  input  logic               q_valid,
  output logic               q_pop,
  input  fstc_pkg::cmd_t     q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fstc_pkg::out_item_t out_data
);
  import fstc_pkg::*;
  localparam int IW = $clog2(NUM_FADERS);

  logic [14:0] level [NUM_FADERS];
  logic [14:0] sent  [NUM_FADERS];
  logic [14:0] pivot [NUM_FADERS];
  logic [14:0] start [NUM_FADERS];
  logic [NUM_FADERS-1:0] pact, ever;
  logic        lsb_phase;

  state_t      state, state_next;
  cmd_t        cur;
  logic [IW:0] scan;
  logic        found;
  out_item_t   hold;
  logic        advance, emit;
  out_item_t   emit_data;
  logic [14:0] m_lvl, m_piv, m_st;
  logic [4:0]  dcnt;
  logic [28:0] num, rem;
  logic [14:0] den, quo;
  logic        up;

  logic [IW-1:0] si;
  logic [14:0] slvl, dl;
  logic        need;
  logic [28:0] f14;
  logic [6:0]  vnum, vval;

  // scan helpers
  always_comb begin
    si   = scan[IW-1:0];
    slvl = level[si];
    dl   = (slvl > sent[si]) ? slvl - sent[si] : sent[si] - slvl;
    need = !ever[si] || (dl > 15'(CHANGE_THR));
    f14  = (29'(slvl) * 29'd16383 + 29'd8192) >> 14;
    if (!wide) begin
      vnum = 7'(32'(si) + 1);
      vval = 7'((22'(slvl) * 22'd127 + 22'd8192) >> 14);
    end else if (lsb_phase) begin
      vnum = 7'(32'(si) + 32);
      vval = f14[6:0];
    end else begin
      vnum = 7'(si);
      vval = (f14[28:7] > 22'd127) ? 7'd127 : f14[13:7];
    end
  end

  // target of the finished divide, clamped
  logic [15:0] tgt;
  logic [14:0] tgt15, dct;
  always_comb begin
    logic [15:0] t;
    t = up ? 16'(m_st) + 16'(quo) : 16'(m_st) - 16'(quo);
    if (cur.pos == m_piv) t = 16'(m_st);
    else if (up && (15'(Q_ONE - 32'(m_piv)) <= 15'(RANGE_MIN))) t = 16'(Q_ONE);
    else if (!up && m_piv <= 15'(RANGE_MIN)) t = 16'd0;
    tgt   = (t > 16'(Q_ONE)) ? 16'(Q_ONE) : t;
    tgt15 = tgt[14:0];
    dct   = (cur.pos > tgt15) ? cur.pos - tgt15 : tgt15 - cur.pos;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (q_valid) state_next = (q_data.kind == KIND_TICK) ? ST_TSCAN : ST_MREAD;
      ST_MREAD: state_next = (!cur.ok) ? ST_IDLE : (pact[cur.idx[IW-1:0]] ? ST_MDIV : ST_MDONE);
      ST_MDIV:  if (dcnt == 5'd0) state_next = ST_MDONE;
      ST_MDONE: state_next = ST_IDLE;
      ST_TSCAN: if (scan == (IW+1)'(NUM_FADERS)) state_next = ST_TEND;
      ST_TEND:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs: the held message goes out when the next one is found, or at the
  // end of the scan with the last flag set
  always_comb begin
    q_pop     = (state == ST_IDLE) && q_valid;
    advance   = !out_valid || !out_stall;
    emit      = 1'b0;
    emit_data = hold;
    case (state)
      ST_TSCAN: emit = (scan != (IW+1)'(NUM_FADERS)) && advance && need && found;
      ST_TEND: begin
        emit = advance && found;
        emit_data.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; pact <= '0; ever <= '0; lsb_phase <= 1'b0;
      out_valid <= 1'b0; found <= 1'b0; scan <= '0;
      for (int k = 0; k < NUM_FADERS; k++) begin
        level[k] <= '0; sent[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
        out_data  <= emit_data;
      end else if (!out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin cur <= q_data; scan <= '0; found <= 1'b0; end
        end
        ST_MREAD: begin
          m_lvl <= level[cur.idx[IW-1:0]];
          m_piv <= pivot[cur.idx[IW-1:0]];
          m_st  <= start[cur.idx[IW-1:0]];
          up  <= cur.pos > pivot[cur.idx[IW-1:0]];
          if (cur.pos > pivot[cur.idx[IW-1:0]]) begin
            den <= 15'(Q_ONE - 32'(pivot[cur.idx[IW-1:0]]));
            num <= 29'(cur.pos - pivot[cur.idx[IW-1:0]]) *
                   29'(Q_ONE - 32'(start[cur.idx[IW-1:0]])) +
                   29'((Q_ONE - 32'(pivot[cur.idx[IW-1:0]])) >> 1);
          end else begin
            den <= pivot[cur.idx[IW-1:0]];
            num <= 29'(pivot[cur.idx[IW-1:0]] - cur.pos) *
                   29'(start[cur.idx[IW-1:0]]) +
                   29'(pivot[cur.idx[IW-1:0]] >> 1);
          end
          rem <= '0; quo <= '0; dcnt <= 5'd28;
        end
        ST_MDIV: begin
          // restoring divide, one bit per cycle; quotient fits 15 bits
          logic [29:0] r2;
          r2 = {rem, num[28]};
          num <= {num[27:0], 1'b0};
          if (r2 >= 30'(den) && den != '0) begin
            rem <= 29'(r2 - 30'(den)); quo <= {quo[13:0], 1'b1};
          end else begin
            rem <= r2[28:0]; quo <= {quo[13:0], 1'b0};
          end
          dcnt <= dcnt - 5'd1;
        end
        ST_MDONE: begin
          if (!pact[cur.idx[IW-1:0]]) begin
            if (((cur.pos > m_lvl) ? cur.pos - m_lvl : m_lvl - cur.pos) > 15'(ENTER_THR)) begin
              pact[cur.idx[IW-1:0]]  <= 1'b1;
              pivot[cur.idx[IW-1:0]] <= cur.pos;
              start[cur.idx[IW-1:0]] <= m_lvl;
            end else level[cur.idx[IW-1:0]] <= cur.pos;
          end else if (dct < 15'(CATCH_THR)) begin
            pact[cur.idx[IW-1:0]]  <= 1'b0;
            level[cur.idx[IW-1:0]] <= cur.pos;
          end else level[cur.idx[IW-1:0]] <= tgt15;
        end
        ST_TSCAN: begin
          // one fader per cycle; hold while a pending message is not taken
          if (scan != (IW+1)'(NUM_FADERS) && advance) begin
            if (need) begin
              found <= 1'b1;
              hold  <= '{cc_number: vnum, cc_value: vval, last: 1'b0};
              if (!wide || lsb_phase) begin sent[si] <= slvl; ever[si] <= 1'b1; end
            end
            scan <= scan + 1'b1;
          end
        end
        ST_TEND: begin
          if (advance && wide) lsb_phase <= ~lsb_phase;
        end
        default: ;
      endcase
    end
  end

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> state == ST_IDLE || state == ST_MREAD ||
      state == ST_TSCAN || state == ST_TEND || state == ST_MDIV || state == ST_MDONE)
    else $error("last flag state");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("pending message changed");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop on empty queue");
endmodule

[sv/fader_soft_takeover_cc_emitter_top.sv]
// ----------------------------------------------------------------------------
// fader_soft_takeover_cc_emitter_top
// Soft-takeover fader bank with MIDI CC emitter.
// ----------------------------------------------------------------------------
// A taken request is registered in the front's queue before it reaches the
// back. There a move passes ST_MREAD and ST_MDONE and, in pickup, the 29-step
// one-bit-per-cycle restoring divider in ST_MDIV between them. A tick scans
// one fader per cycle while the output is not stalled. A two-entry queue
// between the front and the back lets input be taken during that work.
module fader_soft_takeover_cc_emitter_top #(
  parameter int NUM_FADERS      = 32,
  parameter int FADERS_PER_PAGE = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fstc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fstc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [1:0]          cfg_data
);
  import fstc_pkg::*;

  logic [1:0] page;
  logic       wide;
  logic       q_valid, q_pop;
  cmd_t       q_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page <= 2'd0; wide <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGE: page <= cfg_data;
        CFG_WIDE: wide <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fstc_front #(.NUM_FADERS(NUM_FADERS), .FADERS_PER_PAGE(FADERS_PER_PAGE)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .page,
    .q_valid, .q_pop, .q_data
  );

  fstc_back #(.NUM_FADERS(NUM_FADERS)) u_back (
    .clk, .rst, .wide, .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .out_data
  );
endmodule
